// ===== rtl/rmq_pkg.sv =====
// rmq_pkg: shared constants and word types for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ONE       = 1 << FRAC_BITS;

	// pipeline depths: two root bits per sqrt stage, two quotient bits per divide stage but one in the last
	localparam int SQ_STG  = 8;
	localparam int DV_STG  = 8;
	localparam int DV_BITS = 15;
	localparam int LATENCY = 4 + SQ_STG + DV_STG;

	localparam logic [1:0] BR_TRACE   = 2'd0;
	localparam logic [1:0] BR_PIVOT_X = 2'd1;
	localparam logic [1:0] BR_PIVOT_Y = 2'd2;
	localparam logic [1:0] BR_PIVOT_Z = 2'd3;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} rmq_in_t;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic [1:0]         branch_taken;
	} rmq_out_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// rotation_matrix_to_quaternion_top: pipelined 3x3 rotation matrix to quaternion conversion
// depends on rmq_pkg
//
// usage
//   input channel: mat carries the nine signed Q1.14 matrix entries; a word is taken at a
//   rising edge with start high and busy low. busy is always low: the pipeline never stops,
//   so a new matrix may be offered on every cycle.
//   result channel: res carries quat_w/x/y/z in Q1.14 (saturated to +-1.0) and the branch
//   code; it is valid for exactly one cycle while done is high. the receiver cannot stall.
//   throughput: one matrix per cycle, set by the fully pipelined square root
//   (8 stages, two root bits each) and the three parallel restoring dividers
//   (8 stages, two quotient bits each, one in the last).
//   pipeline: entry/trace/pivot, radicand, sqrt x8, divider setup, divide x8, output.
//   reset: arst_n clears all stage valid bits at once; words in flight are dropped and no
//   done pulse follows until new words are accepted.
//   zero radicand (only for matrices that are not rotations) gives all-zero components
//   while the branch code still names the pivot.
module rotation_matrix_to_quaternion_top
	import rmq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  rmq_in_t  mat,
	output logic     done,
	output rmq_out_t res
);

	typedef struct packed {
		logic [19:0] rem;
		logic [15:0] rt;
		logic [31:0] v;
	} sq_t;

	typedef struct packed {
		logic [16:0]         rem;
		logic [DV_BITS-1:0]  lo;
		logic [DV_BITS-1:0]  q;
	} dv_t;

	wire accept = start && !busy;
	assign busy = 1'b0;

	// ---------------- stage 1: trace, pivot, lane differences ----------------
	logic               vld_s1;
	logic               pos_s1;
	logic [1:0]         br_s1;
	logic signed [15:0] a_s1, b_s1, c_s1;
	logic signed [16:0] ln_s1 [3];

	logic signed [17:0] tr;
	logic               pos;
	logic [1:0]         piv;
	logic signed [16:0] ln [3];
	logic signed [15:0] da, db, dc;

	always_comb begin
		tr  = 18'(mat.m00) + 18'(mat.m11) + 18'(mat.m22);
		pos = tr > 18'sd0;
		piv = (mat.m11 > mat.m00) ? 2'd1 : 2'd0;
		if (mat.m22 > ((piv == 2'd1) ? mat.m11 : mat.m00)) piv = 2'd2;
		da = mat.m00;
		db = mat.m11;
		dc = mat.m22;
		// lanes are the non-half slots in w,x,y,z order
		ln[0] = 17'(mat.m12) - 17'(mat.m21);
		ln[1] = 17'(mat.m20) - 17'(mat.m02);
		ln[2] = 17'(mat.m01) - 17'(mat.m10);
		if (!pos) begin
			case (piv)
				2'd0: begin
					ln[0] = 17'(mat.m12) - 17'(mat.m21);
					ln[1] = 17'(mat.m01) + 17'(mat.m10);
					ln[2] = 17'(mat.m02) + 17'(mat.m20);
				end
				2'd1: begin
					da = mat.m11; db = mat.m22; dc = mat.m00;
					ln[0] = 17'(mat.m20) - 17'(mat.m02);
					ln[1] = 17'(mat.m10) + 17'(mat.m01);
					ln[2] = 17'(mat.m12) + 17'(mat.m21);
				end
				default: begin
					da = mat.m22; db = mat.m00; dc = mat.m11;
					ln[0] = 17'(mat.m01) - 17'(mat.m10);
					ln[1] = 17'(mat.m20) + 17'(mat.m02);
					ln[2] = 17'(mat.m21) + 17'(mat.m12);
				end
			endcase
		end
	end

	// ---------------- stage 2: radicand ----------------
	logic signed [18:0] rad;
	logic               rad_zero;

	always_comb begin
		if (pos_s1) rad = 19'(a_s1) + 19'(b_s1) + 19'(c_s1) + 19'(ONE);
		else        rad = 19'(a_s1) - 19'(b_s1) - 19'(c_s1) + 19'(ONE);
		rad_zero = rad <= 19'sd0;
	end

	// ---------------- sqrt pipe, index 0 is the stage 2 register ----------------
	logic               sq_vld_s [SQ_STG+1];
	logic [1:0]         sq_br_s  [SQ_STG+1];
	logic               sq_zero_s[SQ_STG+1];
	sq_t                sq_s     [SQ_STG+1];
	logic signed [16:0] sq_ln_s  [SQ_STG+1][3];

	sq_t sq_nxt [SQ_STG];

	always_comb begin
		logic [19:0] rem2;
		logic [19:0] trial;
		for (int k = 0; k < SQ_STG; k++) begin
			sq_nxt[k] = sq_s[k];
			for (int t = 0; t < 2; t++) begin
				rem2  = {sq_nxt[k].rem[17:0], sq_nxt[k].v[31:30]};
				trial = {2'b00, sq_nxt[k].rt, 2'b01};
				if (rem2 >= trial) begin
					sq_nxt[k].rem = rem2 - trial;
					sq_nxt[k].rt  = {sq_nxt[k].rt[14:0], 1'b1};
				end else begin
					sq_nxt[k].rem = rem2;
					sq_nxt[k].rt  = {sq_nxt[k].rt[14:0], 1'b0};
				end
				sq_nxt[k].v = {sq_nxt[k].v[29:0], 2'b00};
			end
		end
	end

	// ---------------- divider setup ----------------
	wire [15:0] root = sq_s[SQ_STG].rt;
	logic [16:0] half17;
	logic [15:0] half;
	logic [16:0] den;
	logic        neg [3];
	logic        ovf [3];
	dv_t         dv0 [3];

	always_comb begin
		logic [16:0] mag;
		logic [31:0] num;
		half17 = (17'(root) + 17'd1) >> 1;
		half   = (half17 > 17'(ONE)) ? 16'(ONE) : half17[15:0];
		den    = {root, 1'b0};
		for (int l = 0; l < 3; l++) begin
			neg[l] = sq_ln_s[SQ_STG][l] < 17'sd0;
			mag    = neg[l] ? 17'(-sq_ln_s[SQ_STG][l]) : 17'(sq_ln_s[SQ_STG][l]);
			// round to nearest: (mag*one*2 + den) / (2*den) = (mag*one + root) / den
			num    = (32'(mag) << FRAC_BITS) + 32'(root);
			ovf[l] = num[31:DV_BITS] >= den;
			dv0[l].rem = num[31:DV_BITS];
			dv0[l].lo  = num[DV_BITS-1:0];
			dv0[l].q   = '0;
		end
	end

	// ---------------- divide pipe, index 0 is the setup register ----------------
	logic        dv_vld_s [DV_STG+1];
	logic [1:0]  dv_br_s  [DV_STG+1];
	logic        dv_zero_s[DV_STG+1];
	logic [15:0] dv_half_s[DV_STG+1];
	logic [16:0] dv_den_s [DV_STG+1];
	logic        dv_neg_s [DV_STG+1][3];
	logic        dv_ovf_s [DV_STG+1][3];
	dv_t         dv_s     [DV_STG+1][3];

	dv_t dv_nxt [DV_STG][3];

	always_comb begin
		logic [17:0] rem2;
		for (int k = 0; k < DV_STG; k++) begin
			for (int l = 0; l < 3; l++) begin
				dv_nxt[k][l] = dv_s[k][l];
				for (int t = 0; t < 2; t++) begin
					if (2 * k + t < DV_BITS) begin
						rem2 = {dv_nxt[k][l].rem, dv_nxt[k][l].lo[DV_BITS-1]};
						if (rem2 >= {1'b0, dv_den_s[k]}) begin
							dv_nxt[k][l].rem = 17'(rem2 - {1'b0, dv_den_s[k]});
							dv_nxt[k][l].q   = {dv_nxt[k][l].q[DV_BITS-2:0], 1'b1};
						end else begin
							dv_nxt[k][l].rem = rem2[16:0];
							dv_nxt[k][l].q   = {dv_nxt[k][l].q[DV_BITS-2:0], 1'b0};
						end
						dv_nxt[k][l].lo = {dv_nxt[k][l].lo[DV_BITS-2:0], 1'b0};
					end
				end
			end
		end
	end

	// ---------------- output assembly ----------------
	logic signed [15:0] lane_val [3];
	logic signed [15:0] slot [4];

	always_comb begin
		logic [15:0] qm;
		logic [1:0]  br;
		logic signed [15:0] hv;
		for (int l = 0; l < 3; l++) begin
			if (dv_ovf_s[DV_STG][l] || (16'(dv_s[DV_STG][l].q) > 16'(ONE))) qm = 16'(ONE);
			else qm = 16'(dv_s[DV_STG][l].q);
			lane_val[l] = dv_neg_s[DV_STG][l] ? -$signed(qm) : $signed(qm);
		end
		br = dv_br_s[DV_STG];
		hv = $signed(dv_half_s[DV_STG]);
		// the half-root slot is named by the branch code, lanes fill the rest in order
		slot[0] = (br == BR_TRACE)   ? hv : lane_val[0];
		slot[1] = (br == BR_PIVOT_X) ? hv : ((br == BR_TRACE) ? lane_val[0] : lane_val[1]);
		slot[2] = (br == BR_PIVOT_Y) ? hv : ((br == BR_PIVOT_Z) ? lane_val[2] : lane_val[1]);
		slot[3] = (br == BR_PIVOT_Z) ? hv : lane_val[2];
		if (dv_zero_s[DV_STG]) begin
			for (int s = 0; s < 4; s++) slot[s] = '0;
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
			for (int k = 0; k <= SQ_STG; k++) sq_vld_s[k] <= 1'b0;
			for (int k = 0; k <= DV_STG; k++) dv_vld_s[k] <= 1'b0;
		end else begin
			vld_s1      <= accept;
			sq_vld_s[0] <= vld_s1;
			for (int k = 0; k < SQ_STG; k++) sq_vld_s[k+1] <= sq_vld_s[k];
			dv_vld_s[0] <= sq_vld_s[SQ_STG];
			for (int k = 0; k < DV_STG; k++) dv_vld_s[k+1] <= dv_vld_s[k];
			done        <= dv_vld_s[DV_STG];
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		pos_s1 <= pos;
		br_s1  <= pos ? BR_TRACE : (piv + 2'd1);
		a_s1   <= da;
		b_s1   <= db;
		c_s1   <= dc;
		for (int l = 0; l < 3; l++) ln_s1[l] <= ln[l];

		sq_br_s[0]   <= br_s1;
		sq_zero_s[0] <= rad_zero;
		sq_s[0].rem  <= '0;
		sq_s[0].rt   <= '0;
		sq_s[0].v    <= rad_zero ? 32'd0 : (32'(rad[16:0]) << FRAC_BITS);
		for (int l = 0; l < 3; l++) sq_ln_s[0][l] <= ln_s1[l];
		for (int k = 0; k < SQ_STG; k++) begin
			sq_br_s[k+1]   <= sq_br_s[k];
			sq_zero_s[k+1] <= sq_zero_s[k];
			sq_s[k+1]      <= sq_nxt[k];
			for (int l = 0; l < 3; l++) sq_ln_s[k+1][l] <= sq_ln_s[k][l];
		end

		dv_br_s[0]   <= sq_br_s[SQ_STG];
		dv_zero_s[0] <= sq_zero_s[SQ_STG];
		dv_half_s[0] <= half;
		dv_den_s[0]  <= den;
		for (int l = 0; l < 3; l++) begin
			dv_neg_s[0][l] <= neg[l];
			dv_ovf_s[0][l] <= ovf[l];
			dv_s[0][l]     <= dv0[l];
		end
		for (int k = 0; k < DV_STG; k++) begin
			dv_br_s[k+1]   <= dv_br_s[k];
			dv_zero_s[k+1] <= dv_zero_s[k];
			dv_half_s[k+1] <= dv_half_s[k];
			dv_den_s[k+1]  <= dv_den_s[k];
			for (int l = 0; l < 3; l++) begin
				dv_neg_s[k+1][l] <= dv_neg_s[k][l];
				dv_ovf_s[k+1][l] <= dv_ovf_s[k][l];
				dv_s[k+1][l]     <= dv_nxt[k][l];
			end
		end

		res.quat_w       <= slot[0];
		res.quat_x       <= slot[1];
		res.quat_y       <= slot[2];
		res.quat_z       <= slot[3];
		res.branch_taken <= dv_br_s[DV_STG];
	end

`ifndef SYNTH
	// every accepted word is followed by its done pulse
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted word did not produce a result");

	// no result without a matching accepted word
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without an accepted word");

	// in the positive trace branch w is half the root, never negative
	a_trace_w: assert property (@(posedge clk) disable iff (!arst_n)
		done && (res.branch_taken == BR_TRACE) |-> (res.quat_w >= 16'sd0))
		else $error("negative w in positive trace branch");
`endif

endmodule
